>>> rtl/core/ptwr_pkg.sv
package ptwr_pkg;

  localparam int OP_W      = 2;
  localparam int ADDR_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int ELAPSED_W = 10;
  localparam int SUBDIV_W  = 9;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_DIVIDER = 16'hFF04;
  localparam logic [ADDR_W-1:0] ADDR_COUNTER = 16'hFF05;
  localparam logic [ADDR_W-1:0] ADDR_RELOAD  = 16'hFF06;
  localparam logic [ADDR_W-1:0] ADDR_CONTROL = 16'hFF07;

  localparam logic [BYTE_W-1:0]    READ_UNMAPPED = 8'hFF;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 10'd1023;

  localparam int CTRL_ENABLE_BIT = 2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] cycles;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              timer_irq;
  } result_t;

  // counter period selected by control bits 1:0
  function automatic logic [ELAPSED_W-1:0] period_of(input logic [1:0] sel);
    logic [ELAPSED_W-1:0] p;
    unique case (sel)
      2'd0:    p = 10'd256;
      2'd1:    p = 10'd4;
      2'd2:    p = 10'd16;
      default: p = 10'd64;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/ptwr_in_stage.sv
module ptwr_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ptwr_pkg::item_t in_item,
  input  logic            take,
  output logic            full,
  output ptwr_pkg::item_t item
);

  assign in_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> rtl/core/ptwr_timer.sv
module ptwr_timer #(
  parameter int DIV_PERIOD = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  ptwr_pkg::item_t   item,
  output ptwr_pkg::result_t result
);

  logic [ptwr_pkg::ELAPSED_W-1:0] elapsed_count, elapsed_count_next;
  logic [ptwr_pkg::SUBDIV_W-1:0]  div_subcount, div_subcount_next;
  logic [ptwr_pkg::BYTE_W-1:0]    divider, divider_next;
  logic [ptwr_pkg::BYTE_W-1:0]    counter, counter_next;
  logic [ptwr_pkg::BYTE_W-1:0]    reload_value, reload_value_next;
  logic [ptwr_pkg::BYTE_W-1:0]    control, control_next;

  logic [ptwr_pkg::ELAPSED_W:0]   elapsed_sum;
  logic [ptwr_pkg::ELAPSED_W-1:0] elapsed_sat;
  logic [ptwr_pkg::SUBDIV_W:0]    sub_sum;
  logic [ptwr_pkg::BYTE_W-1:0]    counter_inc;
  logic                           step;

  always_comb begin
    elapsed_sum = {1'b0, elapsed_count} + (ptwr_pkg::ELAPSED_W+1)'(item.cycles);
    elapsed_sat = elapsed_sum[ptwr_pkg::ELAPSED_W] ? ptwr_pkg::ELAPSED_MAX
                                                   : elapsed_sum[ptwr_pkg::ELAPSED_W-1:0];
    sub_sum     = {1'b0, div_subcount} + (ptwr_pkg::SUBDIV_W+1)'(item.cycles);
    counter_inc = counter + 8'd1;
    step        = control[ptwr_pkg::CTRL_ENABLE_BIT]
                  && (elapsed_sat >= ptwr_pkg::period_of(control[1:0]));

    elapsed_count_next = elapsed_count;
    div_subcount_next  = div_subcount;
    divider_next       = divider;
    counter_next       = counter;
    reload_value_next  = reload_value;
    control_next       = control;
    result.read_data   = '0;
    result.timer_irq   = 1'b0;

    unique case (item.op)
      ptwr_pkg::OP_TICK: begin
        elapsed_count_next = step ? '0 : elapsed_sat;
        if (step) begin
          if (counter_inc == '0) begin
            counter_next     = reload_value;
            result.timer_irq = 1'b1;
          end else begin
            counter_next = counter_inc;
          end
        end
        // sum wraps at the accumulator width
        if (sub_sum[ptwr_pkg::SUBDIV_W-1:0] >= ptwr_pkg::SUBDIV_W'(DIV_PERIOD)) begin
          divider_next      = divider + 8'd1;
          div_subcount_next = '0;
        end else begin
          div_subcount_next = sub_sum[ptwr_pkg::SUBDIV_W-1:0];
        end
      end
      ptwr_pkg::OP_READ: begin
        unique case (item.addr)
          ptwr_pkg::ADDR_DIVIDER: result.read_data = divider;
          ptwr_pkg::ADDR_COUNTER: result.read_data = counter;
          ptwr_pkg::ADDR_RELOAD:  result.read_data = reload_value;
          ptwr_pkg::ADDR_CONTROL: result.read_data = control;
          default:                result.read_data = ptwr_pkg::READ_UNMAPPED;
        endcase
      end
      ptwr_pkg::OP_WRITE: begin
        unique case (item.addr)
          ptwr_pkg::ADDR_DIVIDER: divider_next      = '0;
          ptwr_pkg::ADDR_COUNTER: counter_next      = item.wdata;
          ptwr_pkg::ADDR_RELOAD:  reload_value_next = item.wdata;
          ptwr_pkg::ADDR_CONTROL: control_next      = item.wdata;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_count <= '0;
      div_subcount  <= '0;
      divider       <= '0;
      counter       <= '0;
      reload_value  <= '0;
      control       <= '0;
    end else if (fire) begin
      elapsed_count <= elapsed_count_next;
      div_subcount  <= div_subcount_next;
      divider       <= divider_next;
      counter       <= counter_next;
      reload_value  <= reload_value_next;
      control       <= control_next;
    end
  end

endmodule

>>> rtl/core/prescaled_timer_with_reload_unit.sv
// channel   direction  handshake            payload
// input     in         in_valid / in_ready   op, addr, wdata, cycles
// result    out        out_valid / out_ready read_data, timer_irq
//
// one transfer in and one result out per clock when both sides flow
// an item is held in the input register, then is executed against the
// timer state and lands in the result register
// rst is synchronous and clears the stage flags and every timer register
// a stalled result holds the executing item in the input register; a new item
// is still taken in the cycle the result register drains
module prescaled_timer_with_reload_unit #(
  parameter int DIV_PERIOD = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] addr,
  input  logic [7:0]  wdata,
  input  logic [7:0]  cycles,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        timer_irq
);

  ptwr_pkg::item_t   in_item;
  ptwr_pkg::item_t   item;
  ptwr_pkg::result_t result;
  ptwr_pkg::result_t result_q;
  logic              full;
  logic              fire;

  assign in_item.op     = op;
  assign in_item.addr   = addr;
  assign in_item.wdata  = wdata;
  assign in_item.cycles = cycles;

  // held item executes when the result register is free or being emptied
  assign fire = full && (!out_valid || out_ready);

  ptwr_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (fire),
    .full     (full),
    .item     (item)
  );

  // timer state, bus decode and tick arithmetic
  ptwr_timer #(
    .DIV_PERIOD (DIV_PERIOD)
  ) u_timer (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign read_data = result_q.read_data;
  assign timer_irq = result_q.timer_irq;

endmodule
